// ===== rtl/gsd_pkg.sv =====
// Shared types, constants and helpers for the signed gadget decomposition block.
// No dependencies; imported by every module of the block.
`default_nettype none

package gsd_pkg;

    localparam int MAX_DIGITS   = 16;
    localparam int COEF_W       = 62;
    localparam int WORK_W       = 64;
    localparam int SHIFT_W      = 6;
    localparam int COUNT_W      = 5;
    localparam int INDEX_W      = 4;
    localparam int REG_INDEX_W  = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;

    // register indexes of the configuration port
    localparam logic [REG_INDEX_W-1:0] REG_MODULUS     = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_GADGET_BITS = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_BASE_BITS   = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_DIGIT_COUNT = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_DROP_MODE   = 3'd4;

    localparam logic [COEF_W-1:0]  MODULUS_RESET     = 62'd1125899906826241;
    localparam logic [SHIFT_W-1:0] GADGET_BITS_RESET = 6'd8;
    localparam logic [SHIFT_W-1:0] BASE_BITS_RESET   = 6'd0;
    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 5'd4;
    localparam logic               DROP_MODE_FLOOR   = 1'b1;
    localparam logic               DROP_MODE_RESET   = 1'b0;

    typedef struct packed {
        logic [COEF_W-1:0]  modulus;
        logic [SHIFT_W-1:0] gadget_bits;
        logic [SHIFT_W-1:0] base_bits;
        logic [COUNT_W-1:0] digit_count;
        logic               drop_mode;
    } gsd_cfg_t;

    // one classified coefficient waiting for digit extraction
    typedef struct packed {
        logic [WORK_W-1:0]  value;
        logic [COUNT_W-1:0] count;
    } gsd_entry_t;

    function automatic logic [WORK_W-1:0] sar64(input logic [WORK_W-1:0] x,
                                                input logic [SHIFT_W-1:0] s);
        sar64 = WORK_W'($signed(x) >>> s);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gsd_front.sv =====
// Front end: accepts coefficients, centers them, drops the low base bits.
// Depends on gsd_pkg; feeds gsd_queue.
`default_nettype none

module gsd_front
    import gsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gsd_cfg_t           cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [COEF_W-1:0]  coefficient,
    input  wire logic               queue_full,
    output logic                    push,
    output gsd_entry_t              push_data
);

    logic               s1_valid_reg, s1_valid_next;
    logic [WORK_W-1:0]  s1_value_reg;
    logic [COUNT_W-1:0] s1_count_reg;
    logic [COEF_W-1:0]  half;
    logic [WORK_W-1:0]  centered;
    logic [COUNT_W-1:0] count_sat;
    logic               accept;
    logic [SHIFT_W-1:0] round_pos;
    logic [WORK_W-1:0]  shifted;
    logic               round_up;

    assign in_stall = s1_valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;
    assign push     = s1_valid_reg && !queue_full;

    always_comb
    begin
        half = cfg.modulus >> 1;
        if (coefficient > half)
            centered = {2'b00, coefficient} - {2'b00, cfg.modulus};
        else
            centered = {2'b00, coefficient};
        if (cfg.digit_count > COUNT_W'(MAX_DIGITS))
            count_sat = COUNT_W'(MAX_DIGITS);
        else
            count_sat = cfg.digit_count;
    end

    // rounding: subtracting the centered low field then shifting equals
    // the floor shift plus the top dropped bit
    always_comb
    begin
        round_pos = cfg.base_bits - 6'd1;
        shifted   = sar64(s1_value_reg, cfg.base_bits);
        round_up  = (cfg.base_bits != '0) && (cfg.drop_mode != DROP_MODE_FLOOR)
                    && s1_value_reg[round_pos];
        push_data.value = shifted + {{(WORK_W-1){1'b0}}, round_up};
        push_data.count = s1_count_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = (count_sat != '0);  // drop items with no digits
        else if (push)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= centered;
            s1_count_reg <= count_sat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gsd_queue.sv =====
// Short queue between the front end and the digit engine.
// Depends on gsd_pkg for the entry type and depth.
`default_nettype none

module gsd_queue
    import gsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire gsd_entry_t push_data,
    input  wire logic       pop,
    output logic            full,
    output logic            empty,
    output gsd_entry_t      head
);

    gsd_entry_t             entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg, fill_next;

    assign full  = (fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/gsd_back.sv =====
// Digit engine: peels one signed base-2^g digit per cycle off a queued value,
// unless stalled. Depends on gsd_pkg; drives the block's output register.
`default_nettype none

module gsd_back
    import gsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gsd_cfg_t           cfg,
    input  wire logic               queue_empty,
    input  wire gsd_entry_t         head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COEF_W-1:0]       digit,
    output logic [INDEX_W-1:0]      digit_index,
    output logic                    last
);

    logic               busy_reg, busy_next;
    logic [WORK_W-1:0]  value_reg, value_next;
    logic [COUNT_W-1:0] count_reg;
    logic [INDEX_W-1:0] pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [COEF_W-1:0]  digit_reg;
    logic [INDEX_W-1:0] digit_index_reg;
    logic               last_reg;

    logic               advance;
    logic               emit;
    logic               cur_last;
    logic               finish;
    logic [6:0]         ext_shift;
    logic [WORK_W-1:0]  low_field;
    logic [WORK_W-1:0]  step_value;
    logic [WORK_W-1:0]  residue;

    assign out_valid   = out_valid_reg;
    assign digit       = digit_reg;
    assign digit_index = digit_index_reg;
    assign last        = last_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && advance;
    assign cur_last = (({1'b0, pos_reg} + 5'd1) == count_reg);
    assign finish   = emit && cur_last;
    assign pop      = !queue_empty && (!busy_reg || finish);

    // (v - r) >>> g equals (v >>> g) plus the digit's sign bit
    always_comb
    begin
        ext_shift = 7'd64 - {1'b0, cfg.gadget_bits};
        if (cfg.gadget_bits == '0)
        begin
            low_field  = '0;
            step_value = value_reg;
        end
        else
        begin
            low_field  = WORK_W'($signed(value_reg << ext_shift) >>> ext_shift);
            step_value = sar64(value_reg, cfg.gadget_bits)
                         + {{(WORK_W-1){1'b0}}, low_field[WORK_W-1]};
        end
        if (low_field[WORK_W-1])
            residue = low_field + {2'b00, cfg.modulus};
        else
            residue = low_field;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            value_next = head.value;
            pos_next   = '0;
        end
        else if (finish)
            busy_next = 1'b0;
        else if (emit)
        begin
            value_next = step_value;
            pos_next   = pos_reg + 1'b1;
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
        if (pop)
            count_reg <= head.count;
        if (emit)
        begin
            digit_reg       <= residue[COEF_W-1:0];
            digit_index_reg <= pos_reg;
            last_reg        <= cur_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/signed_gadget_decompose_unit.sv =====
// Signed gadget decomposition of ring coefficients: configuration registers,
// front end, queue and digit engine. Depends on gsd_pkg and all gsd_* modules.
//
// Usage:
//   Input channel (in_valid / in_stall / coefficient) takes one residue per beat.
//   Output channel (out_valid / out_stall / digit, digit_index, last) gives the
//   signed digits of each coefficient, least significant first, one per beat;
//   last marks the final digit. Negative digits come out as digit + modulus.
//   Configuration is written through wr_en / wr_index / wr_data; the user must
//   write it only while the block is idle, which the block does not enforce;
//   writes to an index past the drop mode register are ignored.
// A coefficient goes through the front stage register and the queue to the
// digit engine, which produces one digit per cycle while out_stall is low;
// a coefficient gives min(digit_count, 16) digits, back-to-back coefficients
// stream without gaps, and a digit count of zero swallows it with no output.
// Reset clears the pipeline and queue and loads the register reset values.
// When the receiver stalls, the output beat holds; the four-entry queue and
// the front stage keep taking coefficients until the queue fills.
`default_nettype none

module signed_gadget_decompose_unit
    import gsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [REG_INDEX_W-1:0] wr_index,
    input  wire logic [COEF_W-1:0]      wr_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [COEF_W-1:0]      coefficient,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [COEF_W-1:0]           digit,
    output logic [INDEX_W-1:0]          digit_index,
    output logic                        last
);

    gsd_cfg_t   cfg_reg;
    logic       queue_full;
    logic       queue_empty;
    logic       push;
    logic       pop;
    gsd_entry_t push_data;
    gsd_entry_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus     <= MODULUS_RESET;
            cfg_reg.gadget_bits <= GADGET_BITS_RESET;
            cfg_reg.base_bits   <= BASE_BITS_RESET;
            cfg_reg.digit_count <= DIGIT_COUNT_RESET;
            cfg_reg.drop_mode   <= DROP_MODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MODULUS:     cfg_reg.modulus     <= wr_data;
                REG_GADGET_BITS: cfg_reg.gadget_bits <= wr_data[SHIFT_W-1:0];
                REG_BASE_BITS:   cfg_reg.base_bits   <= wr_data[SHIFT_W-1:0];
                REG_DIGIT_COUNT: cfg_reg.digit_count <= wr_data[COUNT_W-1:0];
                REG_DROP_MODE:   cfg_reg.drop_mode   <= wr_data[0];
                default:         ;
            endcase
        end
    end

    gsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coefficient (coefficient),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    gsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head      (head)
    );

    gsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit       (digit),
        .digit_index (digit_index),
        .last        (last)
    );

endmodule

`default_nettype wire
